// ----- sv/dtf_pkg.sv -----
// dtf_pkg: shared types and constants for the depth-tested triangle fragment unit
// no dependencies
`default_nettype none

package dtf_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROD,
        ST_CROSS,
        ST_TEST,
        ST_SUM,
        ST_DIV,
        ST_WB
    } state_t;

    // item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TEST = 1'b1;

    // number of vertex slots
    localparam logic [1:0] SLOT_COUNT = 2'd3;

    // area threshold in 1/256 pixel squared units
    localparam logic signed [35:0] AREA_LIMIT = 36'sd2;

    // one in q1.15
    localparam logic [16:0] ONE_Q15 = 17'd32768;

    // quotient bits of every division
    localparam int Q_BITS = 16;

    // cleared depth value
    localparam logic signed [15:0] DEPTH_MIN = 16'sh8000;

    // divider control
    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

endpackage

`default_nettype wire

// ----- sv/dtf_div.sv -----
// dtf_div: restoring divider, one quotient bit per cycle while step is held
// depends on dtf_pkg (div_ctl_t, Q_BITS)
`default_nettype none

module dtf_div #(
    parameter int NW = 52
) (
    input  wire logic                        clk,
    input  wire dtf_pkg::div_ctl_t           ctl,
    input  wire logic [NW-1:0]               num,
    input  wire logic [NW-1:0]               den,
    output logic [dtf_pkg::Q_BITS-1:0]       quo
);

    logic [NW-1:0]               rem_reg;
    logic [NW-1:0]               den_reg;
    logic [dtf_pkg::Q_BITS-1:0]  quo_reg;
    logic                        fits;

    // divisor arrives pre-shifted to the top quotient bit
    assign fits = (rem_reg >= den_reg);

    // one subtract and compare per step
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rem_reg <= num;
            den_reg <= den;
        end
        else if (ctl.step)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - den_reg;
            end
            quo_reg <= {quo_reg[dtf_pkg::Q_BITS-2:0], fits};
            den_reg <= den_reg >> 1;
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// ----- sv/depth_tested_triangle_fragment.sv -----
// flow: a pixel passes PROD, CROSS, TEST, SUM, DIV and WB; valid is registered from WB;
// a vertex load leaves busy low, a rejected pixel returns to idle from TEST and an
// off-screen one is dropped; a new beat is taken when busy is low, so a pixel waits for
// the 16-step weight and depth dividers and the depth store read-modify-write
// reset: corners clear to zero, then a clearing pass writes the most negative depth to all
// SCREEN_WIDTH*SCREEN_HEIGHT store entries while busy stays high
`default_nettype none

module depth_tested_triangle_fragment #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               mode,
    input  wire logic [1:0]         vertex_slot,
    input  wire logic signed [15:0] vertex_x,
    input  wire logic signed [15:0] vertex_y,
    input  wire logic signed [15:0] vertex_depth,
    input  wire logic [6:0]         pixel_x,
    input  wire logic [6:0]         pixel_y,
    output logic                    valid,
    output logic [6:0]              out_x,
    output logic [6:0]              out_y,
    output logic signed [15:0]      out_depth,
    output logic [15:0]             weight_first,
    output logic [15:0]             weight_second,
    output logic [15:0]             weight_third
);

    localparam int STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);
    localparam int WN_W = 52;
    localparam int ZN_W = 58;

    // state and control
    dtf_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg;
    logic [3:0]        cnt_reg;
    logic              accept;
    logic              off_screen;
    logic [ADDR_W-1:0] pix_addr;

    // corner registers
    logic signed [15:0] corner_x_reg [3];
    logic signed [15:0] corner_y_reg [3];
    logic signed [15:0] corner_depth_reg [3];

    // item payload
    logic [6:0]         px_reg, py_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic signed [15:0] stored_reg;

    // arithmetic pipeline
    logic signed [16:0] s0x, s0y, s0z, s1x, s1y, s1z;
    logic signed [33:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic signed [35:0] ux_next, uy_next, uz_next;
    logic signed [35:0] ux_reg, uy_reg, uz_reg;
    logic signed [36:0] e0;
    logic signed [52:0] dp0_reg, dp1_reg, dp2_reg;
    logic signed [ZN_W-1:0] zn;
    logic               reject;

    // dividers
    dtf_pkg::div_ctl_t w_ctl, z_ctl;
    logic [15:0]       q1, q2, qz;
    logic [WN_W-1:0]   w_den;

    // depth store
    logic signed [15:0] mem [STORE_SIZE];
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic signed [15:0] mem_wdata;
    logic signed [15:0] z_val;
    logic               pass;

    // result registers
    logic               valid_reg;
    logic [6:0]         out_x_reg, out_y_reg;
    logic signed [15:0] out_depth_reg;
    logic [15:0]        w0_reg, w1_reg, w2_reg;

    // input beat decode
    assign accept     = start && (state_reg == dtf_pkg::ST_IDLE);
    assign off_screen = (13'(pixel_x) >= 13'(SCREEN_WIDTH))
                     || (13'(pixel_y) >= 13'(SCREEN_HEIGHT));
    assign pix_addr   = ADDR_W'(ADDR_W'(pixel_y) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(pixel_x));

    // edge vectors
    assign s0x = 17'(corner_x_reg[2]) - 17'(corner_x_reg[0]);
    assign s0y = 17'(corner_x_reg[1]) - 17'(corner_x_reg[0]);
    assign s0z = 17'(corner_x_reg[0]) - $signed({6'd0, px_reg, 4'd0});
    assign s1x = 17'(corner_y_reg[2]) - 17'(corner_y_reg[0]);
    assign s1y = 17'(corner_y_reg[1]) - 17'(corner_y_reg[0]);
    assign s1z = 17'(corner_y_reg[0]) - $signed({6'd0, py_reg, 4'd0});

    // cross product with sign normalization
    always_comb
    begin
        ux_next = 36'(m0_reg) - 36'(m1_reg);
        uy_next = 36'(m2_reg) - 36'(m3_reg);
        uz_next = 36'(m4_reg) - 36'(m5_reg);
        if (uz_next < 0)
        begin
            ux_next = -ux_next;
            uy_next = -uy_next;
            uz_next = -uz_next;
        end
    end

    // area and inside tests
    assign e0     = 37'(uz_reg) - 37'(ux_reg) - 37'(uy_reg);
    assign reject = (uz_reg <= dtf_pkg::AREA_LIMIT) || (ux_reg < 0) || (uy_reg < 0)
                 || (e0 < 0);

    // offset numerator keeps the depth quotient non-negative
    assign zn = ((ZN_W'(dp0_reg) + ZN_W'(dp1_reg) + ZN_W'(dp2_reg)) <<< 1)
              + ZN_W'(uz_reg) + (ZN_W'(uz_reg) <<< 16);

    assign w_den = WN_W'(uz_reg) << 15;

    // weight and depth dividers
    dtf_div #(.NW(WN_W)) u_div_w1 (
        .clk (clk),
        .ctl (w_ctl),
        .num (WN_W'(uy_reg) << 15),
        .den (w_den),
        .quo (q1)
    );

    dtf_div #(.NW(WN_W)) u_div_w2 (
        .clk (clk),
        .ctl (w_ctl),
        .num (WN_W'(ux_reg) << 15),
        .den (w_den),
        .quo (q2)
    );

    dtf_div #(.NW(ZN_W)) u_div_z (
        .clk (clk),
        .ctl (z_ctl),
        .num (zn),
        .den (ZN_W'(uz_reg) << 16),
        .quo (qz)
    );

    // depth compare
    assign z_val = $signed({~qz[15], qz[14:0]});
    assign pass  = (z_val > stored_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtf_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = dtf_pkg::ST_IDLE;
                end
            end
            dtf_pkg::ST_IDLE:
            begin
                if (accept && (mode == dtf_pkg::MODE_TEST) && !off_screen)
                begin
                    state_next = dtf_pkg::ST_PROD;
                end
            end
            dtf_pkg::ST_PROD:  state_next = dtf_pkg::ST_CROSS;
            dtf_pkg::ST_CROSS: state_next = dtf_pkg::ST_TEST;
            dtf_pkg::ST_TEST:  state_next = reject ? dtf_pkg::ST_IDLE : dtf_pkg::ST_SUM;
            dtf_pkg::ST_SUM:   state_next = dtf_pkg::ST_DIV;
            dtf_pkg::ST_DIV:
            begin
                if (cnt_reg == 4'd0)
                begin
                    state_next = dtf_pkg::ST_WB;
                end
            end
            dtf_pkg::ST_WB:    state_next = dtf_pkg::ST_IDLE;
            default:           state_next = dtf_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        busy       = 1'b1;
        w_ctl      = '0;
        z_ctl      = '0;
        mem_we     = 1'b0;
        mem_waddr  = addr_reg;
        mem_wdata  = z_val;
        case (state_reg)
            dtf_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = dtf_pkg::DEPTH_MIN;
            end
            dtf_pkg::ST_IDLE: busy = 1'b0;
            dtf_pkg::ST_TEST: w_ctl.load = 1'b1;
            dtf_pkg::ST_SUM:  z_ctl.load = 1'b1;
            dtf_pkg::ST_DIV:
            begin
                w_ctl.step = 1'b1;
                z_ctl.step = 1'b1;
            end
            dtf_pkg::ST_WB:   mem_we = pass;
            default:          busy = 1'b1;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtf_pkg::ST_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                corner_x_reg[i]     <= '0;
                corner_y_reg[i]     <= '0;
                corner_depth_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == dtf_pkg::ST_WB) && pass;
            if (state_reg == dtf_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == dtf_pkg::ST_SUM)
            begin
                cnt_reg <= 4'd15;
            end
            else if (state_reg == dtf_pkg::ST_DIV)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            // vertex load, slot three ignored
            if (accept && (mode == dtf_pkg::MODE_LOAD) && (vertex_slot < dtf_pkg::SLOT_COUNT))
            begin
                corner_x_reg[vertex_slot]     <= vertex_x;
                corner_y_reg[vertex_slot]     <= vertex_y;
                corner_depth_reg[vertex_slot] <= vertex_depth;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg   <= pixel_x;
            py_reg   <= pixel_y;
            addr_reg <= pix_addr;
        end
        if (state_reg == dtf_pkg::ST_PROD)
        begin
            m0_reg <= 34'(s0y) * 34'(s1z);
            m1_reg <= 34'(s0z) * 34'(s1y);
            m2_reg <= 34'(s0z) * 34'(s1x);
            m3_reg <= 34'(s0x) * 34'(s1z);
            m4_reg <= 34'(s0x) * 34'(s1y);
            m5_reg <= 34'(s0y) * 34'(s1x);
        end
        if (state_reg == dtf_pkg::ST_CROSS)
        begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
            uz_reg <= uz_next;
        end
        if (state_reg == dtf_pkg::ST_TEST)
        begin
            dp0_reg <= 53'(corner_depth_reg[0]) * 53'(e0);
            dp1_reg <= 53'(corner_depth_reg[1]) * 53'(uy_reg);
            dp2_reg <= 53'(corner_depth_reg[2]) * 53'(ux_reg);
        end
        if ((state_reg == dtf_pkg::ST_WB) && pass)
        begin
            out_x_reg     <= px_reg;
            out_y_reg     <= py_reg;
            out_depth_reg <= z_val;
            w0_reg        <= 16'(dtf_pkg::ONE_Q15 - 17'(q1) - 17'(q2));
            w1_reg        <= q1;
            w2_reg        <= q2;
        end
    end

    // depth store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            stored_reg <= mem[pix_addr];
        end
    end

    assign valid         = valid_reg;
    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign out_depth     = out_depth_reg;
    assign weight_first  = w0_reg;
    assign weight_second = w1_reg;
    assign weight_third  = w2_reg;

endmodule

`default_nettype wire

// ----- sv/dtf_check.sv -----
// dtf_check: port-level assertions for the fragment unit, with its bind
// depends on dtf_pkg and depth_tested_triangle_fragment
`default_nettype none

module dtf_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        mode,
    input wire logic        valid,
    input wire logic [15:0] weight_first,
    input wire logic [15:0] weight_second,
    input wire logic [15:0] weight_third
);

    // a result beat is never followed by another at once
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("back-to-back result beats");

    // a vertex load leaves the unit free in the next cycle
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == dtf_pkg::MODE_LOAD)) |=> !busy)
        else $error("vertex load kept the unit busy");

    // weights always sum to one
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> ((17'(weight_first) + 17'(weight_second) + 17'(weight_third))
                   == dtf_pkg::ONE_Q15))
        else $error("weights do not sum to one");

    // a result only follows work in progress
    a_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid) |-> $past(busy))
        else $error("result beat without a pixel in flight");

endmodule

bind depth_tested_triangle_fragment dtf_check u_dtf_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .valid         (valid),
    .weight_first  (weight_first),
    .weight_second (weight_second),
    .weight_third  (weight_third)
);

`default_nettype wire
